FILE: sv/ssmoc_pkg.sv
// Package for the scan sector minimum obstacle classifier.
// Holds widths, register indexes, action codes, reset values and the word types.
// No dependencies.
`timescale 1ns / 1ps

package ssmoc_pkg;

    localparam int RANGE_BITS        = 16;
    localparam int SECTOR_LENGTH_MAX = 1023;
    localparam int NUM_SECTORS       = 5;

    localparam int LEN_BITS  = $clog2(SECTOR_LENGTH_MAX + 1);
    localparam int IDX_BITS  = $clog2(NUM_SECTORS + 1);
    localparam int CFG_BITS  = (RANGE_BITS > LEN_BITS) ? RANGE_BITS : LEN_BITS;
    localparam int CFG_INDEX_BITS = 2;

    // Register indexes on the configuration port.
    localparam logic [CFG_INDEX_BITS-1:0] REG_CLIP_LIMIT    = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_OBSTACLE_THR  = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SECTOR_LENGTH = 2'd2;

    // Steering action codes.
    localparam logic [1:0] ACT_GOAL = 2'd0;
    localparam logic [1:0] ACT_TURN = 2'd1;
    localparam logic [1:0] ACT_WALL = 2'd2;

    // Reset values: 30 m clip, 3 m threshold, 108 samples per sector.
    localparam logic [RANGE_BITS-1:0] CLIP_RESET   = RANGE_BITS'(7680);
    localparam logic [RANGE_BITS-1:0] THRESH_RESET = RANGE_BITS'(768);
    localparam logic [LEN_BITS-1:0]   LEN_RESET    = LEN_BITS'(108);

    typedef struct packed {
        logic [RANGE_BITS-1:0] range_sample;
        logic                  scan_end;
    } in_word_t;

    typedef struct packed {
        logic [RANGE_BITS-1:0] sector0_min;
        logic [RANGE_BITS-1:0] sector1_min;
        logic [RANGE_BITS-1:0] sector2_min;
        logic [RANGE_BITS-1:0] sector3_min;
        logic [RANGE_BITS-1:0] sector4_min;
        logic [1:0]            action;
        logic                  tie_hold;
    } out_word_t;

    typedef struct packed {
        logic [1:0] action;
        logic       tie_hold;
    } decision_t;

endpackage

FILE: sv/scan_sector_min_obstacle_classifier_core.sv
// Top level of the scan sector minimum obstacle classifier.
// Depends on ssmoc_pkg and instantiates ssmoc_decide.
`timescale 1ns / 1ps

// Usage
// -----
// Range samples arrive one word per cycle on the in channel (valid/ready) unless
// stalled; each word carries a range in 1/256 m units and a scan_end flag on the
// last sample of a scan. Samples are split into five consecutive sectors of
// sector_length samples and each sector keeps its running minimum; samples past
// the fifth sector are dropped. On the scan_end word one result word leaves on
// the out channel with the five minima (each limited to clip_limit), the
// steering action and the tie_hold flag; all other words produce nothing.
//
// Timing: an accepted word is held in the input register and folded from there;
// the result of a scan_end word is loaded into the output register as that word
// leaves, and out_valid rises with it. One word per cycle is sustained while no
// scan_end word waits on a stalled receiver; a single fold-and-decide stage
// lies between the input register and the output register.
//
// A stalled receiver holds the result in the output register. Plain samples
// keep flowing into the sector minima meanwhile; only a scan_end word waits in
// the input register, with in_ready low, until the output register frees up.
//
// Reset clears the valid flags of both pipeline registers, restores the
// configuration registers to 30 m clip, 3 m threshold and 108 samples per
// sector, sets every sector minimum to the clip limit and the previous action
// to go-to-goal. The configuration port is a plain write strobe; writes to
// unknown indexes are ignored.

module scan_sector_min_obstacle_classifier_core
    import ssmoc_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,

    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_BITS-1:0]       cfg_data,

    input  logic                      in_valid,
    output logic                      in_ready,
    input  in_word_t                  in_data,

    output logic                      out_valid,
    input  logic                      out_ready,
    output out_word_t                 out_data
);

    // Configuration registers.
    logic [RANGE_BITS-1:0] clip_limit_reg;
    logic [RANGE_BITS-1:0] threshold_reg;
    logic [LEN_BITS-1:0]   sector_length_reg;

    // Input register.
    logic     s1_valid_reg, s1_valid_next;
    in_word_t s1_data_reg;

    // Scan state.
    logic [RANGE_BITS-1:0] sector_min_reg  [NUM_SECTORS];
    logic [RANGE_BITS-1:0] sector_min_next [NUM_SECTORS];
    logic [LEN_BITS-1:0]   pos_reg, pos_next;
    logic [IDX_BITS-1:0]   idx_reg, idx_next;
    logic [1:0]            prev_action_reg, prev_action_next;

    // Output register.
    logic      out_valid_reg, out_valid_next;
    out_word_t out_data_reg, out_data_next;

    logic                  out_free;
    logic                  s1_go;
    logic                  load_result;
    logic                  in_accept;
    logic                  in_scan;
    logic [LEN_BITS-1:0]   eff_len;
    logic [LEN_BITS:0]     pos_inc;
    logic [RANGE_BITS-1:0] folded  [NUM_SECTORS];
    logic [RANGE_BITS-1:0] clamped [NUM_SECTORS];
    decision_t             decision;

    // The output register frees up in the same cycle its word is taken, so a
    // scan_end word can move on right behind a delivered result.
    assign out_free    = !out_valid_reg || out_ready;
    assign s1_go       = s1_valid_reg && (!s1_data_reg.scan_end || out_free);
    assign load_result = s1_go && s1_data_reg.scan_end;
    assign in_ready    = !s1_valid_reg || s1_go;
    assign in_accept   = in_valid && in_ready;

    assign s1_valid_next = in_accept ? 1'b1 : (s1_go ? 1'b0 : s1_valid_reg);

    // A programmed length of zero behaves as one sample per sector.
    assign eff_len = (sector_length_reg == '0) ? LEN_BITS'(1) : sector_length_reg;
    assign pos_inc = {1'b0, pos_reg} + (LEN_BITS + 1)'(1);
    assign in_scan = (idx_reg < IDX_BITS'(NUM_SECTORS));

    // Fold the current sample into the minimum of its sector, then limit every
    // minimum by the current clip value for the report.
    always_comb
    begin
        for (int i = 0; i < NUM_SECTORS; i++)
        begin
            if ((idx_reg == IDX_BITS'(i)) && (s1_data_reg.range_sample < sector_min_reg[i]))
            begin
                folded[i] = s1_data_reg.range_sample;
            end
            else
            begin
                folded[i] = sector_min_reg[i];
            end
            clamped[i] = (folded[i] > clip_limit_reg) ? clip_limit_reg : folded[i];
        end
    end

    ssmoc_decide u_decide (
        .left_min    (clamped[1]),
        .front_min   (clamped[2]),
        .right_min   (clamped[3]),
        .threshold   (threshold_reg),
        .prev_action (prev_action_reg),
        .decision    (decision)
    );

    always_comb
    begin
        sector_min_next  = sector_min_reg;
        pos_next         = pos_reg;
        idx_next         = idx_reg;
        prev_action_next = prev_action_reg;
        if (s1_go)
        begin
            if (load_result)
            begin
                // A new scan starts from the clip value in force right now.
                for (int i = 0; i < NUM_SECTORS; i++)
                begin
                    sector_min_next[i] = clip_limit_reg;
                end
                pos_next         = '0;
                idx_next         = '0;
                prev_action_next = decision.action;
            end
            else if (in_scan)
            begin
                sector_min_next = folded;
                if (pos_inc >= {1'b0, eff_len})
                begin
                    pos_next = '0;
                    idx_next = idx_reg + IDX_BITS'(1);
                end
                else
                begin
                    pos_next = pos_inc[LEN_BITS-1:0];
                end
            end
        end
    end

    always_comb
    begin
        out_data_next.sector0_min = clamped[0];
        out_data_next.sector1_min = clamped[1];
        out_data_next.sector2_min = clamped[2];
        out_data_next.sector3_min = clamped[3];
        out_data_next.sector4_min = clamped[4];
        out_data_next.action      = decision.action;
        out_data_next.tie_hold    = decision.tie_hold;
    end

    assign out_valid_next = load_result ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    // Control state and configuration.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clip_limit_reg    <= CLIP_RESET;
            threshold_reg     <= THRESH_RESET;
            sector_length_reg <= LEN_RESET;
            s1_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
            pos_reg           <= '0;
            idx_reg           <= '0;
            prev_action_reg   <= ACT_GOAL;
            for (int i = 0; i < NUM_SECTORS; i++)
            begin
                sector_min_reg[i] <= CLIP_RESET;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_CLIP_LIMIT:    clip_limit_reg    <= cfg_data[RANGE_BITS-1:0];
                    REG_OBSTACLE_THR:  threshold_reg     <= cfg_data[RANGE_BITS-1:0];
                    REG_SECTOR_LENGTH: sector_length_reg <= cfg_data[LEN_BITS-1:0];
                    default:           ;
                endcase
            end
            s1_valid_reg    <= s1_valid_next;
            out_valid_reg   <= out_valid_next;
            pos_reg         <= pos_next;
            idx_reg         <= idx_next;
            prev_action_reg <= prev_action_next;
            sector_min_reg  <= sector_min_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_data_reg <= in_data;
        end
        if (load_result)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // The sector index saturates once all five sectors are filled.
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg <= IDX_BITS'(NUM_SECTORS))
        else $error("sector index ran past the last sector");

    // A pending result always carries the action that was recorded as previous.
    a_prev_matches: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (prev_action_reg == out_data_reg.action))
        else $error("previous action differs from the pending result");

    // No action code outside the three defined ones is ever reported.
    a_action_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((out_data_reg.action == ACT_GOAL)
                        || (out_data_reg.action == ACT_TURN)
                        || (out_data_reg.action == ACT_WALL)))
        else $error("undefined action code in result");

    // Emitting a result restarts the scan at the first sector.
    a_scan_restart: assert property (@(posedge clk) disable iff (!rst_n)
        load_result |=> ((idx_reg == '0) && (pos_reg == '0) && out_valid_reg))
        else $error("scan did not restart after a result");

endmodule

FILE: sv/ssmoc_decide.sv
// Steering decision from the front-left, front and front-right sector minima.
// Depends on ssmoc_pkg for widths, action codes and the decision struct.
`timescale 1ns / 1ps

module ssmoc_decide
    import ssmoc_pkg::*;
(
    input  logic [RANGE_BITS-1:0] left_min,
    input  logic [RANGE_BITS-1:0] front_min,
    input  logic [RANGE_BITS-1:0] right_min,
    input  logic [RANGE_BITS-1:0] threshold,
    input  logic [1:0]            prev_action,
    output decision_t             decision
);

    logic tie;

    assign tie = (left_min == threshold) || (front_min == threshold)
              || (right_min == threshold);

    always_comb
    begin
        decision.tie_hold = tie;
        if (tie)
        begin
            // A sector sitting exactly on the threshold is ambiguous; keep course.
            decision.action = prev_action;
        end
        else if (front_min < threshold)
        begin
            decision.action = ACT_TURN;
        end
        else if ((left_min < threshold) && (right_min > threshold))
        begin
            decision.action = ACT_WALL;
        end
        else
        begin
            decision.action = ACT_GOAL;
        end
    end

endmodule
